@@ src/bpdc_pkg.sv @@
// Package for the button press duration classifier.
// Holds payload structs, result and register codes, sizes and the controller state type.
// No dependencies.
package bpdc_pkg;

	localparam int BUTTON_COUNT = 4;
	localparam int NUM_SLOTS    = 8;
	localparam int BTN_W        = $clog2(BUTTON_COUNT);
	localparam int SLOT_W       = $clog2(NUM_SLOTS);
	localparam int TICK_W       = 32;
	localparam int CFG_IDX_W    = 2;

	localparam logic [TICK_W-1:0] DEBOUNCE_RST    = 32'd10;
	localparam logic [TICK_W-1:0] SHORT_LIMIT_RST = 32'd700;
	localparam logic [TICK_W-1:0] LONG_LIMIT_RST  = 32'd10000;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 2'd2;

	localparam logic CMD_SAMPLE    = 1'b0;
	localparam logic CMD_SUBSCRIBE = 1'b1;

	localparam logic [1:0] KIND_GRANTED = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_NOTICE  = 2'd2;

	localparam logic GESTURE_SHORT = 1'b0;
	localparam logic GESTURE_LONG  = 1'b1;

	typedef struct packed {
		logic                    command;
		logic [BUTTON_COUNT-1:0] button_levels;
		logic [TICK_W-1:0]       time_now;
		logic [BTN_W-1:0]        subscribe_button;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] slot;
		logic [BTN_W-1:0]  button;
		logic              gesture;
		logic              last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLASS,
		ST_NOTIFY
	} state_t;

	typedef struct packed {
		logic capture;
		logic sub_emit;
		logic load_held;
		logic classify;
		logic idx_inc;
		logic notice_emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_sub;
		logic released;
		logic idx_last;
		logic any_match;
		logic one_left;
		logic out_free;
	} dp_stat_t;

endpackage

@@ src/bpdc_ctrl.sv @@
// Controller state machine of the button press duration classifier.
// Sequences button scan, classification and subscriber notices.
// Depends on bpdc_pkg.
module bpdc_ctrl import bpdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.is_sub) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else if (stat.released) begin
					state_d = ST_CLASS;
				end else if (stat.idx_last) begin
					state_d = ST_NOTIFY;
				end
			end
			ST_CLASS: begin
				state_d = stat.idx_last ? ST_NOTIFY : ST_SCAN;
			end
			ST_NOTIFY: begin
				if (!stat.any_match) begin
					state_d = ST_IDLE;
				end else if (stat.out_free && stat.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall  = 1'b0;
				cmd.capture = item_valid;
			end
			ST_SCAN: begin
				if (stat.is_sub) begin
					cmd.sub_emit = stat.out_free;
				end else if (stat.released) begin
					cmd.load_held = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			ST_NOTIFY: begin
				cmd.notice_emit = stat.any_match && stat.out_free;
			end
			default: begin
				cmd        = '0;
				item_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ src/bpdc_dp.sv @@
// Datapath of the button press duration classifier.
// Holds configuration, button history, press times, subscriber slots and the result register.
// Depends on bpdc_pkg.
module bpdc_dp import bpdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  item_t                item,
	output result_t              result,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat
);

	logic [TICK_W-1:0]       debounce_q, short_limit_q, long_limit_q;
	logic [BUTTON_COUNT-1:0] prev_levels_q;
	logic [TICK_W-1:0]       press_time_q [BUTTON_COUNT];
	logic [NUM_SLOTS-1:0]    slot_used_q;
	logic [BTN_W-1:0]        slot_btn_q [NUM_SLOTS];
	item_t                   item_q;
	logic [BUTTON_COUNT-1:0] released_q;
	logic [BUTTON_COUNT-1:0] gest_ok_q;
	logic [BUTTON_COUNT-1:0] gest_long_q;
	logic [BTN_W-1:0]        idx_q;
	logic [TICK_W-1:0]       held_q;
	result_t                 result_q;
	logic                    result_valid_q;

	logic [BUTTON_COUNT-1:0] changed;
	logic                    out_free;
	logic [SLOT_W-1:0]       free_slot;
	logic                    free_found;
	logic [NUM_SLOTS-1:0]    match;
	logic [SLOT_W-1:0]       pick_slot;
	logic [BTN_W-1:0]        pick_btn;
	logic                    within_short, within_long, above_debounce;

	assign changed  = item.button_levels ^ prev_levels_q;
	assign out_free = !result_valid_q || !result_stall;

	// Lowest free slot for a subscribe request.
	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (!slot_used_q[s]) begin
				free_slot  = SLOT_W'(s);
				free_found = 1'b1;
			end
		end
	end

	// Next notice: lowest button first, then lowest slot waiting on it.
	always_comb begin
		pick_slot = '0;
		pick_btn  = '0;
		for (int b = BUTTON_COUNT - 1; b >= 0; b--) begin
			for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
				if (slot_used_q[s] && slot_btn_q[s] == BTN_W'(b) && gest_ok_q[b]) begin
					pick_slot = SLOT_W'(s);
					pick_btn  = BTN_W'(b);
				end
			end
		end
	end

	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			match[s] = slot_used_q[s] && gest_ok_q[slot_btn_q[s]];
		end
	end

	assign above_debounce = held_q >= debounce_q;
	assign within_short   = held_q <= short_limit_q;
	assign within_long    = held_q <= long_limit_q;

	always_comb begin
		stat.is_sub    = item_q.command == CMD_SUBSCRIBE;
		stat.released  = released_q[idx_q];
		stat.idx_last  = idx_q == BTN_W'(BUTTON_COUNT - 1);
		stat.any_match = |match;
		stat.one_left  = $countones(match) == 1;
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			short_limit_q <= SHORT_LIMIT_RST;
			long_limit_q  <= LONG_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:    debounce_q    <= cfg_data;
				CFG_SHORT_LIMIT: short_limit_q <= cfg_data;
				CFG_LONG_LIMIT:  long_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q  <= '1;
			slot_used_q    <= '0;
			released_q     <= '0;
			gest_ok_q      <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_btn_q[s] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				idx_q     <= '0;
				gest_ok_q <= '0;
				if (item.command == CMD_SAMPLE) begin
					prev_levels_q <= item.button_levels;
					released_q    <= changed & item.button_levels;
				end else begin
					released_q <= '0;
				end
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.classify) begin
				gest_ok_q[idx_q] <= above_debounce && (within_short || within_long);
			end
			if (cmd.sub_emit && free_found) begin
				slot_used_q[free_slot] <= 1'b1;
				slot_btn_q[free_slot]  <= item_q.subscribe_button;
			end
			if (cmd.notice_emit) begin
				slot_used_q[pick_slot] <= 1'b0;
			end
			if (cmd.sub_emit || cmd.notice_emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			if (item.command == CMD_SAMPLE) begin
				for (int b = 0; b < BUTTON_COUNT; b++) begin
					if (changed[b] && !item.button_levels[b]) begin
						press_time_q[b] <= item.time_now;
					end
				end
			end
		end
		if (cmd.load_held) begin
			held_q <= item_q.time_now - press_time_q[idx_q];
		end
		if (cmd.classify) begin
			gest_long_q[idx_q] <= within_short ? GESTURE_SHORT : GESTURE_LONG;
		end
		if (cmd.sub_emit) begin
			result_q.kind    <= free_found ? KIND_GRANTED : KIND_FULL;
			result_q.slot    <= free_found ? free_slot : '0;
			result_q.button  <= item_q.subscribe_button;
			result_q.gesture <= GESTURE_SHORT;
			result_q.last    <= 1'b1;
		end else if (cmd.notice_emit) begin
			result_q.kind    <= KIND_NOTICE;
			result_q.slot    <= pick_slot;
			result_q.button  <= pick_btn;
			result_q.gesture <= gest_long_q[pick_btn];
			result_q.last    <= $countones(match) == 1;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

@@ src/button_press_duration_classifier.sv @@
// Top level of the button press duration classifier.
// Joins the controller and the datapath. Depends on bpdc_pkg, bpdc_ctrl and bpdc_dp.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    item   (item_t)
//   result    result_valid / result_stall result (result_t)
//   config    cfg_write                  cfg_index, cfg_data
//
// One item is in work at a time. A subscribe holds the block through capture and the slot
// grant; its result is registered at the grant, once the result register is free.
// A pin sample is captured, then the button scan steps through each button, with an extra
// classify step per released button, then the slot scan sends one notice per waiting slot,
// or ends at once when there is none. Result stalls hold the block only while the result
// register is full.
// Reset marks every button released, frees every slot and loads the default limits;
// press times have no reset.
module button_press_duration_classifier import bpdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bpdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	bpdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
